// File: hdl/bec_pkg.sv
// Shared types, constants and arithmetic helpers for the block edge-count update.
package bec_pkg;

    // Sizes of the fields and stores.
    localparam int IDX_W       = 10;
    localparam int BLOCK_COUNT = 1 << IDX_W;
    localparam int CNT_W       = 32;
    localparam int WGT_W       = 31;
    localparam int ACT_W       = 3;

    // Command queue between the front and the back; the depth is a power of two
    // so the pointers wrap on their own.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Action codes carried in the input beat.
    localparam logic [ACT_W-1:0] ACT_LOAD   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_BEGIN  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_IN_NB  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_OUT_NB = 3'd3;
    localparam logic [ACT_W-1:0] ACT_FINISH = 3'd4;
    localparam logic [ACT_W-1:0] ACT_READ   = 3'd5;

    // Saturation bounds of the counts.
    localparam logic signed [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};
    localparam logic signed [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};

    // Input beat.
    typedef struct packed {
        logic [ACT_W-1:0]        action;
        logic [IDX_W-1:0]        block_index;
        logic [WGT_W-1:0]        edge_weight;
        logic signed [CNT_W-1:0] load_current_row;
        logic signed [CNT_W-1:0] load_current_col;
        logic signed [CNT_W-1:0] load_proposal_row;
        logic signed [CNT_W-1:0] load_proposal_col;
        logic [IDX_W-1:0]        from_block;
        logic [IDX_W-1:0]        to_block;
        logic [WGT_W-1:0]        self_weight;
    } req_t;

    // Result beat.
    typedef struct packed {
        logic [IDX_W-1:0]        read_index;
        logic signed [CNT_W-1:0] row_of_current;
        logic signed [CNT_W-1:0] col_of_current;
        logic signed [CNT_W-1:0] row_of_proposal;
        logic signed [CNT_W-1:0] col_of_proposal;
    } rsp_t;

    // Command classes decoded by the front.
    typedef enum logic [2:0] {
        CMD_LOAD,
        CMD_BEGIN,
        CMD_IN_NB,
        CMD_OUT_NB,
        CMD_FINISH,
        CMD_READ
    } cmd_kind_t;

    // One queued command.
    typedef struct packed {
        cmd_kind_t kind;
        req_t      data;
    } cmd_t;

    // Signed add that clamps to the count range.
    function automatic logic signed [CNT_W-1:0] sat_add(
        input logic signed [CNT_W-1:0] a,
        input logic signed [CNT_W-1:0] b
    );
        logic signed [CNT_W:0] sum;
        sum = {a[CNT_W-1], a} + {b[CNT_W-1], b};
        if (sum[CNT_W] != sum[CNT_W-1])
        begin
            return sum[CNT_W] ? CNT_MIN : CNT_MAX;
        end
        return sum[CNT_W-1:0];
    endfunction

endpackage

// File: hdl/block_edge_count_update.sv
// Top level of the block edge-count update: front end, command queue and back end.
//
// Usage: input beats arrive on req_valid/req_ready with one req_t payload each.
// The action field selects load, begin, in-neighbor, out-neighbor, finish or
// read; codes 6 and 7 are accepted and ignored. Only a read produces a result
// beat, on rsp_valid/rsp_ready with one rsp_t payload.
// Flow: the front end takes one beat per cycle into a two-entry queue while it
// is not full. The back end applies a load or begin as it pops it when idle.
// A neighbor update reads the registered-output RAMs and then writes; a finish
// updates the leaving block the same way, then reads and writes the joining one.
// A read beat passes through the queue, the registered store read and the output
// register before it shows up on rsp.
// Reset: clears the queue, the hit counts, the latched block numbers and the
// output valid flag. The stores are not cleared; each entry must be loaded
// before it is updated or read.
// Stall: when rsp_ready is low, one result waits in the output register while
// the back end keeps working; a second read then waits and the queue fills,
// after which req_ready drops.
module block_edge_count_update
    import bec_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    logic q_valid;
    logic q_pop;
    cmd_t q_cmd;

    bec_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_cmd     (q_cmd)
    );

    bec_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_cmd     (q_cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

// File: hdl/bec_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module bec_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/bec_front.sv
// Front end: accepts input beats, classifies the action and queues commands.
module bec_front
    import bec_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic q_valid,
    input  logic q_pop,
    output cmd_t q_cmd
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    cmd_kind_t         kind;
    logic              known;
    logic              push;

    // Classify the action; unused codes are accepted and dropped.
    always_comb
    begin
        known = 1'b1;
        kind  = CMD_LOAD;
        unique case (req.action)
            ACT_LOAD:   kind = CMD_LOAD;
            ACT_BEGIN:  kind = CMD_BEGIN;
            ACT_IN_NB:  kind = CMD_IN_NB;
            ACT_OUT_NB: kind = CMD_OUT_NB;
            ACT_FINISH: kind = CMD_FINISH;
            ACT_READ:   kind = CMD_READ;
            default:    known = 1'b0;
        endcase
    end

    assign req_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push      = req_valid && req_ready && known;
    assign q_valid   = (count_reg != '0);
    assign q_cmd     = entry_reg[rd_ptr_reg];

    // Queue pointers and fill count.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = QPTR_W'(wr_ptr_reg + 1'b1);
        end
        if (q_pop)
        begin
            rd_ptr_next = QPTR_W'(rd_ptr_reg + 1'b1);
        end
        if (push && !q_pop)
        begin
            count_next = QCNT_W'(count_reg + 1'b1);
        end
        else if (!push && q_pop)
        begin
            count_next = QCNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= '{kind: kind, data: req};
        end
    end

endmodule

// File: hdl/bec_back.sv
// Back end: executes queued commands against the four row and column stores.
module bec_back
    import bec_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    output logic q_pop,
    input  cmd_t q_cmd,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_NB_WR    = 6'b000010,
        S_FIN_WR_L = 6'b000100,
        S_FIN_RD_J = 6'b001000,
        S_FIN_WR_J = 6'b010000,
        S_RD_WAIT  = 6'b100000
    } state_t;

    state_t                  state_reg, state_next;
    cmd_t                    cmd_reg, cmd_next;
    logic [IDX_W-1:0]        leaving_reg, leaving_next;
    logic [IDX_W-1:0]        joining_reg, joining_next;
    logic signed [CNT_W-1:0] in_hits_cur_reg, in_hits_cur_next;
    logic signed [CNT_W-1:0] out_hits_cur_reg, out_hits_cur_next;
    logic signed [CNT_W-1:0] in_hits_prop_reg, in_hits_prop_next;
    logic signed [CNT_W-1:0] out_hits_prop_reg, out_hits_prop_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    rsp_t                    rsp_reg, rsp_next;

    logic [IDX_W-1:0]        rd_addr, wr_addr;
    logic                    we_crow, we_ccol, we_prow, we_pcol;
    logic signed [CNT_W-1:0] wd_crow, wd_ccol, wd_prow, wd_pcol;
    logic signed [CNT_W-1:0] rd_crow, rd_ccol, rd_prow, rd_pcol;
    logic signed [CNT_W-1:0] q_weight, cmd_weight;

    assign q_weight   = {1'b0, q_cmd.data.edge_weight};
    assign cmd_weight = {1'b0, cmd_reg.data.edge_weight};

    // Block-matrix stores.
    bec_ram #(.WIDTH(CNT_W), .DEPTH(BLOCK_COUNT)) u_crow (
        .clk(clk), .we(we_crow), .waddr(wr_addr), .wdata(wd_crow),
        .raddr(rd_addr), .rdata(rd_crow)
    );
    bec_ram #(.WIDTH(CNT_W), .DEPTH(BLOCK_COUNT)) u_ccol (
        .clk(clk), .we(we_ccol), .waddr(wr_addr), .wdata(wd_ccol),
        .raddr(rd_addr), .rdata(rd_ccol)
    );
    bec_ram #(.WIDTH(CNT_W), .DEPTH(BLOCK_COUNT)) u_prow (
        .clk(clk), .we(we_prow), .waddr(wr_addr), .wdata(wd_prow),
        .raddr(rd_addr), .rdata(rd_prow)
    );
    bec_ram #(.WIDTH(CNT_W), .DEPTH(BLOCK_COUNT)) u_pcol (
        .clk(clk), .we(we_pcol), .waddr(wr_addr), .wdata(wd_pcol),
        .raddr(rd_addr), .rdata(rd_pcol)
    );

    // Sequencer: each read-modify-write of a store is a read, then a write in the next cycle.
    always_comb
    begin
        state_next         = state_reg;
        cmd_next           = cmd_reg;
        leaving_next       = leaving_reg;
        joining_next       = joining_reg;
        in_hits_cur_next   = in_hits_cur_reg;
        out_hits_cur_next  = out_hits_cur_reg;
        in_hits_prop_next  = in_hits_prop_reg;
        out_hits_prop_next = out_hits_prop_reg;
        rsp_valid_next     = rsp_valid_reg && !rsp_ready;
        rsp_next           = rsp_reg;
        q_pop              = 1'b0;
        rd_addr            = cmd_reg.data.block_index;
        wr_addr            = cmd_reg.data.block_index;
        we_crow            = 1'b0;
        we_ccol            = 1'b0;
        we_prow            = 1'b0;
        we_pcol            = 1'b0;
        wd_crow            = '0;
        wd_ccol            = '0;
        wd_prow            = '0;
        wd_pcol            = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                rd_addr = (q_cmd.kind == CMD_FINISH) ? leaving_reg
                                                     : q_cmd.data.block_index;
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_cmd;
                    unique case (q_cmd.kind)
                        CMD_LOAD:
                        begin
                            wr_addr = q_cmd.data.block_index;
                            we_crow = 1'b1;
                            we_ccol = 1'b1;
                            we_prow = 1'b1;
                            we_pcol = 1'b1;
                            wd_crow = q_cmd.data.load_current_row;
                            wd_ccol = q_cmd.data.load_current_col;
                            wd_prow = q_cmd.data.load_proposal_row;
                            wd_pcol = q_cmd.data.load_proposal_col;
                        end
                        CMD_BEGIN:
                        begin
                            leaving_next       = q_cmd.data.from_block;
                            joining_next       = q_cmd.data.to_block;
                            in_hits_cur_next   = '0;
                            out_hits_cur_next  = '0;
                            in_hits_prop_next  = {1'b0, q_cmd.data.self_weight};
                            out_hits_prop_next = {1'b0, q_cmd.data.self_weight};
                        end
                        CMD_IN_NB:
                        begin
                            if (q_cmd.data.block_index == leaving_reg)
                            begin
                                in_hits_cur_next = sat_add(in_hits_cur_reg, q_weight);
                            end
                            if (q_cmd.data.block_index == joining_reg)
                            begin
                                in_hits_prop_next = sat_add(in_hits_prop_reg, q_weight);
                            end
                            state_next = S_NB_WR;
                        end
                        CMD_OUT_NB:
                        begin
                            if (q_cmd.data.block_index == leaving_reg)
                            begin
                                out_hits_cur_next = sat_add(out_hits_cur_reg, q_weight);
                            end
                            if (q_cmd.data.block_index == joining_reg)
                            begin
                                out_hits_prop_next = sat_add(out_hits_prop_reg, q_weight);
                            end
                            state_next = S_NB_WR;
                        end
                        CMD_FINISH: state_next = S_FIN_WR_L;
                        CMD_READ:   state_next = S_RD_WAIT;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end

            // Move the neighbor weight from the current store to the proposal store.
            S_NB_WR:
            begin
                if (cmd_reg.kind == CMD_IN_NB)
                begin
                    we_ccol = 1'b1;
                    we_pcol = 1'b1;
                    wd_ccol = sat_add(rd_ccol, -cmd_weight);
                    wd_pcol = sat_add(rd_pcol, cmd_weight);
                end
                else
                begin
                    we_crow = 1'b1;
                    we_prow = 1'b1;
                    wd_crow = sat_add(rd_crow, -cmd_weight);
                    wd_prow = sat_add(rd_prow, cmd_weight);
                end
                state_next = S_IDLE;
            end

            // Diagonal fix-ups on the leaving block's entries.
            S_FIN_WR_L:
            begin
                wr_addr    = leaving_reg;
                we_crow    = 1'b1;
                we_ccol    = 1'b1;
                we_prow    = 1'b1;
                we_pcol    = 1'b1;
                wd_prow    = sat_add(rd_prow, -in_hits_prop_reg);
                wd_pcol    = sat_add(rd_pcol, -out_hits_prop_reg);
                wd_crow    = sat_add(rd_crow, -in_hits_cur_reg);
                wd_ccol    = sat_add(rd_ccol, -out_hits_cur_reg);
                state_next = S_FIN_RD_J;
            end

            // Read the joining block's entries after the leaving write has landed.
            S_FIN_RD_J:
            begin
                rd_addr    = joining_reg;
                state_next = S_FIN_WR_J;
            end

            // Diagonal fix-ups on the joining block's entries.
            S_FIN_WR_J:
            begin
                wr_addr    = joining_reg;
                we_crow    = 1'b1;
                we_ccol    = 1'b1;
                we_prow    = 1'b1;
                we_pcol    = 1'b1;
                wd_prow    = sat_add(rd_prow, in_hits_prop_reg);
                wd_pcol    = sat_add(rd_pcol, out_hits_prop_reg);
                wd_crow    = sat_add(rd_crow, in_hits_cur_reg);
                wd_ccol    = sat_add(rd_ccol, out_hits_cur_reg);
                state_next = S_IDLE;
            end

            // Hand the read data to the output register once it is free.
            S_RD_WAIT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = '{read_index:      cmd_reg.data.block_index,
                                       row_of_current:  rd_crow,
                                       col_of_current:  rd_ccol,
                                       row_of_proposal: rd_prow,
                                       col_of_proposal: rd_pcol};
                    state_next     = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            leaving_reg       <= '0;
            joining_reg       <= '0;
            in_hits_cur_reg   <= '0;
            out_hits_cur_reg  <= '0;
            in_hits_prop_reg  <= '0;
            out_hits_prop_reg <= '0;
            rsp_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            leaving_reg       <= leaving_next;
            joining_reg       <= joining_next;
            in_hits_cur_reg   <= in_hits_cur_next;
            out_hits_cur_reg  <= out_hits_cur_next;
            in_hits_prop_reg  <= in_hits_prop_next;
            out_hits_prop_reg <= out_hits_prop_next;
            rsp_valid_reg     <= rsp_valid_next;
        end
    end

    // Command and result payload.
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // A neighbor write always follows the pop of that neighbor command.
    a_nb_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NB_WR) |-> $past(q_pop))
        else $error("neighbor write without a popped command");

    // The joining fix-up is always preceded by its own read cycle.
    a_fin_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN_WR_J) |-> $past(state_reg == S_FIN_RD_J))
        else $error("joining fix-up without a fresh read");

    // Hit counts only ever accumulate non-negative weights.
    a_hits_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        !in_hits_cur_reg[CNT_W-1] && !out_hits_cur_reg[CNT_W-1] &&
        !in_hits_prop_reg[CNT_W-1] && !out_hits_prop_reg[CNT_W-1])
        else $error("hit count went negative");

    // Stores stay untouched while read data waits for the output register.
    a_no_write_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD_WAIT) |-> !(we_crow || we_ccol || we_prow || we_pcol))
        else $error("store written during a pending read");

endmodule
